### sv/heading_hold_pid_mixer_core_assert.svh
// ----------------------------------------------------------------------------
// Heading-hold PID mixer assertion macros
// Implication checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef HEADING_HOLD_PID_MIXER_CORE_ASSERT_SVH
`define HEADING_HOLD_PID_MIXER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HHPM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hhpm assertion failed");
// next-cycle implication
`define HHPM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hhpm assertion failed");
`else
`define HHPM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HHPM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### sv/hhpm_pkg.sv
// ----------------------------------------------------------------------------
// Heading-hold PID mixer package
// Beat types, register indexes, request codes and control structs.
// ----------------------------------------------------------------------------
package hhpm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;
    localparam int QUO_W      = 11;   // rounded correction magnitude bits

    // angle constants, 0.01 degree
    localparam logic signed [17:0] ANG_HALF = 18'sd18000;
    localparam logic signed [17:0] ANG_FULL = 18'sd36000;

    // dt handling, ms
    localparam logic [31:0] DT_MIN     = 32'd10;
    localparam logic [31:0] DT_MAX     = 32'd500;
    localparam logic [8:0]  DT_DEFAULT = 9'd100;
    localparam logic [8:0]  DT_FLOOR   = 9'd10;

    // register reset values
    localparam logic [14:0] RST_DEADBAND   = 15'd150;
    localparam logic [16:0] RST_CORR_LIM   = 17'd500;
    localparam logic [26:0] RST_INTEG_LIM  = 27'd8000000;
    localparam logic [19:0] RST_GAIN_P     = 20'd19661;
    localparam logic [19:0] RST_GAIN_I     = 20'd1311;
    localparam logic [19:0] RST_GAIN_D     = 20'd3932;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND  = 3'd0,
        CFG_CORR_LIM  = 3'd1,
        CFG_INTEG_LIM = 3'd2,
        CFG_GAIN_P    = 3'd3,
        CFG_GAIN_I    = 3'd4,
        CFG_GAIN_D    = 3'd5,
        CFG_FWD_SWAP  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_STOP   = 2'd1,
        REQ_UPDATE = 2'd2
    } t_req;

    // spare request code, ignored by the block
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    localparam logic [1:0] DIR_FORWARD  = 2'd0;
    localparam logic [1:0] DIR_BACKWARD = 2'd1;
    localparam logic [1:0] DIR_OTHER    = 2'd2;
    localparam logic [1:0] DIR_UNUSED   = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] yaw;
        logic [31:0]        now_ms;
        logic [1:0]         direction;
        logic [9:0]         cruise_pwm;
    } t_in_item;

    typedef struct packed {
        logic signed [11:0] left_drive;
        logic signed [11:0] right_drive;
        logic               in_deadband;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic start;
        logic stop;
        logic prep;
        logic integ;
        logic mul1;
        logic mul2;
        logic nsum;
        logic div_step;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] req;
        logic       hold_on;
        logic       dir_ok;
        logic       in_db;
        logic       out_free;
    } t_status;

endpackage

### sv/hhpm_dpath.sv
// ----------------------------------------------------------------------------
// Heading-hold PID mixer datapath
// Config registers, controller state, PID multiplies, divider and mixer.
// ----------------------------------------------------------------------------
module hhpm_dpath
    import hhpm_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_item,
    input  logic                  i_out_stall,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    output t_out_item             o_out
);

    localparam int G  = GAIN_FRAC_BITS;
    localparam int VW = (((37 + G) > 62) ? (37 + G) : 62) + 2;

    // config registers
    logic [14:0] r_deadband;
    logic [16:0] r_corr_lim;
    logic [26:0] r_integ_lim;
    logic [19:0] r_gain_p, r_gain_i, r_gain_d;
    logic        r_fwd_swap;

    // controller state
    logic               r_hold_on;
    logic signed [15:0] r_target;
    logic signed [15:0] r_prev_err;
    logic signed [27:0] r_err_sum;
    logic [31:0]        r_prev_tick;

    // working registers
    t_in_item           r_item;
    logic signed [15:0] r_e;
    logic signed [16:0] r_de;
    logic [8:0]         r_dt;
    logic [18:0]        r_k;
    logic               r_db;
    logic signed [34:0] r_p1;
    logic signed [48:0] r_p2;
    logic signed [36:0] r_p3;
    logic [35:0]        r_capk;
    logic signed [55:0] r_p1b;
    logic signed [58:0] r_p2b;
    logic signed [57:0] r_p3b;
    logic               r_neg;
    logic [VW-1:0]      r_num;
    logic [VW-1:0]      r_dsh;
    logic [QUO_W-1:0]   r_q;
    logic               r_out_valid;
    t_out_item          r_out;

    // heading error wrap
    logic signed [17:0] w0, w1, w2, w3, w4;
    logic signed [17:0] db_s;
    logic               in_db;
    always_comb begin
        w0 = 18'(r_target) - 18'(r_item.yaw);
        w1 = (w0 > ANG_HALF) ? (w0 - ANG_FULL) : w0;
        w2 = (w1 > ANG_HALF) ? (w1 - ANG_FULL) : w1;
        w3 = (w2 < -ANG_HALF) ? (w2 + ANG_FULL) : w2;
        w4 = (w3 < -ANG_HALF) ? (w3 + ANG_FULL) : w3;
        db_s = $signed({3'b000, r_deadband});
        in_db = (w4 > -db_s) && (w4 < db_s);
    end

    // dt from tick difference
    logic [31:0] tick_d;
    logic [8:0]  dt_n;
    always_comb begin
        tick_d = r_item.now_ms - r_prev_tick;
        dt_n = DT_DEFAULT;
        if (r_prev_tick != 32'd0 && r_item.now_ms >= r_prev_tick) begin
            if (tick_d < DT_MIN) begin
                dt_n = DT_FLOOR;
            end else if (tick_d > DT_MAX) begin
                dt_n = DT_DEFAULT;
            end else begin
                dt_n = tick_d[8:0];
            end
        end
    end

    // integral accumulate and clamp
    logic signed [24:0] edt;
    logic signed [28:0] sum_n, lim_s, sum_c;
    always_comb begin
        edt = 25'(r_e) * $signed({16'd0, r_dt});
        sum_n = 29'(r_err_sum) + 29'(edt);
        lim_s = $signed({2'b00, r_integ_lim});
        if (sum_n > lim_s) begin
            sum_c = lim_s;
        end else if (sum_n < -lim_s) begin
            sum_c = -lim_s;
        end else begin
            sum_c = sum_n;
        end
    end

    // correction numerator and divider setup
    logic signed [60:0] n_sum;
    logic [60:0]        mag;
    logic [VW-1:0]      den_w, cap_w, mag_w, base_w;
    logic               sat;
    always_comb begin
        n_sum = 61'(r_p1b) + 61'(r_p2b) + 61'(r_p3b);
        mag = n_sum[60] ? 61'(-n_sum) : 61'(n_sum);
        den_w = VW'(r_k) << G;
        cap_w = VW'(r_capk) << G;
        mag_w = VW'(mag);
        sat = mag_w > cap_w;
        base_w = sat ? cap_w : mag_w;
    end

    // mixer
    logic signed [13:0] b_s, c_s, left_n, right_n;
    always_comb begin
        b_s = $signed({4'd0, r_item.cruise_pwm});
        c_s = r_neg ? -$signed({3'd0, r_q}) : $signed({3'd0, r_q});
        if (r_db) begin
            left_n  = (r_item.direction == DIR_FORWARD) ? b_s : -b_s;
            right_n = left_n;
        end else if (r_item.direction == DIR_FORWARD) begin
            left_n  = r_fwd_swap ? (b_s - c_s) : (b_s + c_s);
            right_n = r_fwd_swap ? (b_s + c_s) : (b_s - c_s);
        end else begin
            left_n  = -b_s - c_s;
            right_n = -b_s + c_s;
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband  <= RST_DEADBAND;
            r_corr_lim  <= RST_CORR_LIM;
            r_integ_lim <= RST_INTEG_LIM;
            r_gain_p    <= RST_GAIN_P;
            r_gain_i    <= RST_GAIN_I;
            r_gain_d    <= RST_GAIN_D;
            r_fwd_swap  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEADBAND:  r_deadband  <= i_cfg_data[14:0];
                CFG_CORR_LIM:  r_corr_lim  <= i_cfg_data[16:0];
                CFG_INTEG_LIM: r_integ_lim <= i_cfg_data[26:0];
                CFG_GAIN_P:    r_gain_p    <= i_cfg_data[19:0];
                CFG_GAIN_I:    r_gain_i    <= i_cfg_data[19:0];
                CFG_GAIN_D:    r_gain_d    <= i_cfg_data[19:0];
                CFG_FWD_SWAP:  r_fwd_swap  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_on   <= 1'b0;
            r_target    <= '0;
            r_prev_err  <= '0;
            r_err_sum   <= '0;
            r_prev_tick <= '0;
        end else if (i_cmd.start) begin
            r_hold_on   <= 1'b1;
            r_target    <= r_item.yaw;
            r_prev_err  <= '0;
            r_err_sum   <= '0;
            r_prev_tick <= r_item.now_ms;
        end else if (i_cmd.stop) begin
            r_hold_on   <= 1'b0;
            r_prev_err  <= '0;
            r_err_sum   <= '0;
            r_prev_tick <= '0;
        end else if (i_cmd.prep) begin
            r_prev_err  <= w4[15:0];
            r_prev_tick <= r_item.now_ms;
            if (in_db) begin
                r_err_sum <= '0;
            end
        end else if (i_cmd.integ) begin
            r_err_sum <= sum_c[27:0];
        end
    end

    // working pipeline of the update
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.prep) begin
            r_e  <= w4[15:0];
            r_de <= 17'(w4) - 17'(r_prev_err);
            r_dt <= dt_n;
            r_k  <= 19'(19'(dt_n) * 19'd1000);
            r_db <= in_db;
        end
        if (i_cmd.mul1) begin
            r_p1   <= 35'(r_e) * $signed({16'd0, r_k});
            r_p2   <= $signed({1'b0, r_gain_i}) * 49'(r_err_sum);
            r_p3   <= 37'(r_de) * 37'sd1000000;
            r_capk <= 36'(r_corr_lim) * 36'(r_k);
        end
        if (i_cmd.mul2) begin
            r_p1b <= $signed({1'b0, r_gain_p}) * 56'(r_p1);
            r_p2b <= 59'(r_p2) * $signed({50'd0, r_dt});
            r_p3b <= $signed({1'b0, r_gain_d}) * 58'(r_p3);
        end
        if (i_cmd.nsum) begin
            r_neg <= n_sum[60];
            r_num <= VW'((base_w << 1) + den_w * VW'(100));
            r_dsh <= VW'((den_w * VW'(200)) << (QUO_W - 1));
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (r_num >= r_dsh) begin
                r_num <= r_num - r_dsh;
                r_q   <= {r_q[QUO_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QUO_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.left_drive  <= left_n[11:0];
            r_out.right_drive <= right_n[11:0];
            r_out.in_deadband <= r_db;
        end
    end

    assign o_status.req      = r_item.req_type;
    assign o_status.hold_on  = r_hold_on;
    assign o_status.dir_ok   = (r_item.direction == DIR_FORWARD)
                             || (r_item.direction == DIR_BACKWARD);
    assign o_status.in_db    = in_db;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

endmodule

### sv/hhpm_ctrl.sv
// ----------------------------------------------------------------------------
// Heading-hold PID mixer controller
// Sequences one item through prepare, then for an update integrate, multiply, divide and mix (deadband: mix only).
// ----------------------------------------------------------------------------
module hhpm_ctrl
    import hhpm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PREP  = 8'b0000_0010,
        ST_INTEG = 8'b0000_0100,
        ST_MUL1  = 8'b0000_1000,
        ST_MUL2  = 8'b0001_0000,
        ST_NSUM  = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_MIX   = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [3:0]       r_cnt, n_cnt;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_IDLE;
                unique case (i_status.req)
                    REQ_START: o_cmd.start = 1'b1;
                    REQ_STOP:  o_cmd.stop  = 1'b1;
                    REQ_UPDATE: begin
                        if (i_status.hold_on && i_status.dir_ok) begin
                            o_cmd.prep = 1'b1;
                            n_state    = i_status.in_db ? ST_MIX : ST_INTEG;
                        end
                    end
                    default: ;
                endcase
            end
            ST_INTEG: begin
                o_cmd.integ = 1'b1;
                n_state     = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_NSUM;
            end
            ST_NSUM: begin
                o_cmd.nsum = 1'b1;
                n_cnt      = 4'(QUO_W - 1);
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_state = ST_MIX;
                end
            end
            ST_MIX: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### sv/heading_hold_pid_mixer_core.sv
// Start and stop act in the prepare state; a deadband update goes from prepare to mix,
//   a full PID update through integrate, multiply, numerator sum, divide and mix.
// Throughput: one item at a time, with no new item taken until the last is done; the
//   rounding divider gives one bit per cycle, and a result stall holds the mix state.
// Reset (synchronous, active low): hold off, history cleared, registers to defaults.
// ----------------------------------------------------------------------------
// Heading-hold PID mixer top level
// Controller and datapath with config write port and output register.
// ----------------------------------------------------------------------------
`include "heading_hold_pid_mixer_core_assert.svh"

module heading_hold_pid_mixer_core
    import hhpm_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    hhpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    hhpm_dpath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // checks
    `HHPM_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `HHPM_ASSERT_IMP(a_db_straight, i_clk, i_rst_n, o_out_valid && o_out.in_deadband, o_out.left_drive == o_out.right_drive)
    `HHPM_ASSERT_IMP(a_div_busy, i_clk, i_rst_n, cmd.div_step || cmd.emit, o_in_stall)

endmodule
